// ----- design/eaur_pkg.sv -----
`default_nettype none

package eaur_pkg;

   localparam int unsigned PeriodWidth = 14;
   localparam int unsigned LevelWidth  = 12;

   localparam logic [PeriodWidth-1:0] FramePeriodReset = 14'd7458;
   localparam logic [LevelWidth-1:0]  LevelReset       = 12'd4080;

   // item kinds
   localparam logic [1:0] ReqTick      = 2'd0;
   localparam logic [1:0] ReqWrite     = 2'd1;
   localparam logic [1:0] ReqStatusRd  = 2'd2;
   localparam logic [1:0] ReqIrqRd     = 2'd3;

   // register addresses
   localparam logic [15:0] AddrCtrlOne   = 16'h5000;
   localparam logic [15:0] AddrLenOne    = 16'h5003;
   localparam logic [15:0] AddrCtrlTwo   = 16'h5004;
   localparam logic [15:0] AddrLenTwo    = 16'h5007;
   localparam logic [15:0] AddrPcmMode   = 16'h5010;
   localparam logic [15:0] AddrPcmDac    = 16'h5011;
   localparam logic [15:0] AddrEnables   = 16'h5015;

   localparam int unsigned HaltBit      = 5;
   localparam int unsigned IrqEnableBit = 7;

   typedef struct packed {
      logic [7:0]            read_data;
      logic [LevelWidth-1:0] dac_level;
      logic                  irq_line;
   } result_type;

   function automatic logic [7:0] length_lookup(input logic [4:0] idx);
      logic [7:0] v;
      case (idx)
         5'd0:  v = 8'h0A;  5'd1:  v = 8'hFE;  5'd2:  v = 8'h14;  5'd3:  v = 8'h02;
         5'd4:  v = 8'h28;  5'd5:  v = 8'h04;  5'd6:  v = 8'h50;  5'd7:  v = 8'h06;
         5'd8:  v = 8'hA0;  5'd9:  v = 8'h08;  5'd10: v = 8'h3C;  5'd11: v = 8'h0A;
         5'd12: v = 8'h0E;  5'd13: v = 8'h0C;  5'd14: v = 8'h1A;  5'd15: v = 8'h0E;
         5'd16: v = 8'h0C;  5'd17: v = 8'h10;  5'd18: v = 8'h18;  5'd19: v = 8'h12;
         5'd20: v = 8'h30;  5'd21: v = 8'h14;  5'd22: v = 8'h60;  5'd23: v = 8'h16;
         5'd24: v = 8'hC0;  5'd25: v = 8'h18;  5'd26: v = 8'h48;  5'd27: v = 8'h1A;
         5'd28: v = 8'h10;  5'd29: v = 8'h1C;  5'd30: v = 8'h20;  default: v = 8'h1E;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- design/expansion_audio_register_unit.sv -----
`default_nettype none
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   req_type, req_addr, req_data
// rsp      out        rsp_valid/rsp_ready   rsp_read_data, rsp_dac_level, rsp_irq_line
// csr      in         csr_valid/csr_ready   csr_data (frame period)
//
// One item per cycle while req_ready is high; its result appears in the cycle after acceptance.
// Throughput is set by the result register: req_ready drops only while a
// result waits and rsp_ready is low, and rises again the cycle it drains.
// Synchronous reset puts all state but the held result data at its power-on values
// (DAC level 4080, frame countdown 1, frame period 7458). csr_ready is always high.

module expansion_audio_register_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_type,
   input  wire logic [15:0]  req_addr,
   input  wire logic [7:0]   req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [7:0]        rsp_read_data,
   output logic [11:0]       rsp_dac_level,
   output logic              rsp_irq_line,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [13:0]  csr_data
);
   import eaur_pkg::*;

   logic [PeriodWidth-1:0] reload_period_ff;
   logic                   take;
   logic                   out_busy;
   result_type             next_result;
   result_type             rsp_data;

   // Frame period register; writes land whenever offered.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) reload_period_ff <= FramePeriodReset;
      else if (csr_valid) reload_period_ff <= csr_data;
   end

   // Accept while the result slot is free or draining.
   assign req_ready = !out_busy;
   assign take      = req_valid && req_ready;

   // State and result logic for one item.
   eaur_core u_core (
      .clock         (clock),
      .reset         (reset),
      .reload_period (reload_period_ff),
      .item_take     (take),
      .item_kind     (req_type),
      .item_addr     (req_addr),
      .item_data     (req_data),
      .result        (next_result)
   );

   // Result register toward the rsp side.
   eaur_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (take),
      .load_data (next_result),
      .taken     (rsp_ready),
      .busy      (out_busy),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign rsp_read_data = rsp_data.read_data;
   assign rsp_dac_level = rsp_data.dac_level;
   assign rsp_irq_line  = rsp_data.irq_line;

   // An accepted item always shows up as a result next cycle.
   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("accepted item produced no result");

   // IRQ status read clears the flag.
   a_irq_read_clears: assert property (@(posedge clock) disable iff (reset)
      take && req_type == ReqIrqRd |=> !rsp_irq_line)
      else $error("irq flag survived a status read");

   // Ticks and writes return zero read data.
   a_no_read_data: assert property (@(posedge clock) disable iff (reset)
      take && (req_type == ReqTick || req_type == ReqWrite) |=> rsp_read_data == 8'h00)
      else $error("nonzero read data on tick or write");

   // DAC level is always a multiple of 16.
   a_level_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dac_level[3:0] == 4'h0)
      else $error("dac level not a multiple of 16");

endmodule

`default_nettype wire

// ----- design/eaur_core.sv -----
`default_nettype none

module eaur_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [eaur_pkg::PeriodWidth-1:0]  reload_period,
   input  wire logic                              item_take,
   input  wire logic [1:0]                        item_kind,
   input  wire logic [15:0]                       item_addr,
   input  wire logic [7:0]                        item_data,
   output eaur_pkg::result_type                   result
);
   import eaur_pkg::*;

   logic [PeriodWidth-1:0] countdown_ff, countdown_in;
   logic [7:0]             len_one_ff, len_one_in, len_two_ff, len_two_in;
   logic                   en_one_ff, en_one_in, en_two_ff, en_two_in;
   logic                   halt_one_ff, halt_one_in, halt_two_ff, halt_two_in;
   logic                   read_mode_ff, read_mode_in;
   logic                   irq_en_ff, irq_en_in;
   logic                   irq_flag_ff, irq_flag_in;
   logic [LevelWidth-1:0]  level_ff, level_in;
   logic [7:0]             rd;
   logic [7:0]             len_load;

   assign len_load = length_lookup(item_data[7:3]);

   always_comb begin
      countdown_in = countdown_ff;
      len_one_in   = len_one_ff;
      len_two_in   = len_two_ff;
      en_one_in    = en_one_ff;
      en_two_in    = en_two_ff;
      halt_one_in  = halt_one_ff;
      halt_two_in  = halt_two_ff;
      read_mode_in = read_mode_ff;
      irq_en_in    = irq_en_ff;
      irq_flag_in  = irq_flag_ff;
      level_in     = level_ff;
      rd           = 8'h00;
      case (item_kind)
         ReqTick: begin
            if (countdown_ff <= PeriodWidth'(1)) begin
               countdown_in = reload_period;
               if (len_one_ff != 8'h00 && !halt_one_ff) len_one_in = len_one_ff - 8'd1;
               if (len_two_ff != 8'h00 && !halt_two_ff) len_two_in = len_two_ff - 8'd1;
            end else begin
               countdown_in = countdown_ff - PeriodWidth'(1);
            end
         end
         ReqWrite: begin
            unique case (item_addr)
               AddrCtrlOne: halt_one_in = item_data[HaltBit];
               AddrCtrlTwo: halt_two_in = item_data[HaltBit];
               AddrLenOne:  if (en_one_ff) len_one_in = len_load;
               AddrLenTwo:  if (en_two_ff) len_two_in = len_load;
               AddrPcmMode: begin
                  read_mode_in = item_data[0];
                  irq_en_in    = item_data[IrqEnableBit];
               end
               AddrPcmDac: begin
                  if (!read_mode_ff) begin
                     if (item_data == 8'h00) irq_flag_in = irq_en_ff;
                     else level_in = {item_data, 4'h0};
                  end
               end
               AddrEnables: begin
                  en_one_in = item_data[0];
                  en_two_in = item_data[1];
                  if (!item_data[0]) len_one_in = 8'h00;
                  if (!item_data[1]) len_two_in = 8'h00;
               end
               default: ;
            endcase
         end
         ReqStatusRd: rd = {6'd0, len_two_ff != 8'h00, len_one_ff != 8'h00};
         default: begin
            rd          = {irq_flag_ff & irq_en_ff, 6'd0, read_mode_ff};
            irq_flag_in = 1'b0;
         end
      endcase
   end

   assign result.read_data = rd;
   assign result.dac_level = level_in;
   assign result.irq_line  = irq_flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= PeriodWidth'(1);
         len_one_ff   <= 8'h00;
         len_two_ff   <= 8'h00;
         en_one_ff    <= 1'b0;
         en_two_ff    <= 1'b0;
         halt_one_ff  <= 1'b0;
         halt_two_ff  <= 1'b0;
         read_mode_ff <= 1'b0;
         irq_en_ff    <= 1'b0;
         irq_flag_ff  <= 1'b0;
         level_ff     <= LevelReset;
      end else if (item_take) begin
         countdown_ff <= countdown_in;
         len_one_ff   <= len_one_in;
         len_two_ff   <= len_two_in;
         en_one_ff    <= en_one_in;
         en_two_ff    <= en_two_in;
         halt_one_ff  <= halt_one_in;
         halt_two_ff  <= halt_two_in;
         read_mode_ff <= read_mode_in;
         irq_en_ff    <= irq_en_in;
         irq_flag_ff  <= irq_flag_in;
         level_ff     <= level_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/eaur_out_reg.sv -----
`default_nettype none

module eaur_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire eaur_pkg::result_type load_data,
   input  wire logic                 taken,
   output logic                      busy,
   output logic                      out_valid,
   output eaur_pkg::result_type      out_data
);
   import eaur_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // full and not draining this cycle
   assign busy     = valid_ff && !taken;
   assign valid_in = load || (valid_ff && !taken);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import eaur_pkg::*;

   // Bit positions inside the written bytes
   localparam int unsigned PcmModeBit   = 0;
   localparam int unsigned EnableOneBit = 0;
   localparam int unsigned EnableTwoBit = 1;

   // Length reload values, entry 0 in the low byte
   localparam logic [255:0] LenReload = {64'h1E201C101A4818C0, 64'h166014301218100C,
                                         64'h0E1A0C0E0A3C08A0, 64'h065004280214FE0A};

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned LongHold   = 400;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
   } bus_op_type;

   typedef enum logic [1:0] {SinkOpen, SinkMostly, SinkSparse, SinkCoin} sink_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type  = ReqTick;
   logic [15:0] req_addr  = 16'd0;
   logic [7:0]  req_data  = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [11:0] rsp_dac_level;
   logic        rsp_irq_line;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [13:0] csr_data  = 14'd0;

   // Bus operations waiting for the driver, and responses the register
   // unit owes us, oldest first.
   bus_op_type pending_bus_ops[$];
   result_type predicted_responses[$];
   int unsigned queued_total = 0;

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Sender burst shaping
   int unsigned burst_left = 1;
   int unsigned gap_left   = 0;

   // Receiver pattern and long hold-off request (ask/seen handshake)
   sink_mode_type sink_mode  = SinkOpen;
   int unsigned   mode_left  = 0;
   int unsigned   hold_left  = 0;
   int unsigned   stall_ask  = 0;
   int unsigned   stall_seen = 0;

   // Shadow copy of the register unit state
   logic [13:0] cfg_period  = FramePeriodReset;
   logic [13:0] frame_left  = 14'd1;
   logic [7:0]  len_one     = 8'd0;
   logic [7:0]  len_two     = 8'd0;
   logic        en_one      = 1'b0;
   logic        en_two      = 1'b0;
   logic        hold_one    = 1'b0;
   logic        hold_two    = 1'b0;
   logic        pcm_rd_mode = 1'b0;
   logic        irq_en      = 1'b0;
   logic        irq_pend    = 1'b0;
   logic [11:0] dac_lvl     = LevelReset;

   expansion_audio_register_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_addr      (req_addr),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_data (rsp_read_data),
      .rsp_dac_level (rsp_dac_level),
      .rsp_irq_line  (rsp_irq_line),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data)
   );

   always #10 clock = ~clock;

   // Advance the shadow state by one accepted item and queue the response
   // it must produce.
   function automatic void predict_register_unit(input logic [1:0] kind,
                                                 input logic [15:0] a,
                                                 input logic [7:0] d);
      result_type r;
      r = '0;
      case (kind)
         ReqTick: begin
            // countdown of 0 or 1 expires on this tick
            if (frame_left <= 14'd1) begin
               frame_left = cfg_period;
               if (len_one != 8'd0 && !hold_one) len_one = len_one - 8'd1;
               if (len_two != 8'd0 && !hold_two) len_two = len_two - 8'd1;
            end else begin
               frame_left = frame_left - 14'd1;
            end
         end
         ReqWrite: begin
            case (a)
               AddrCtrlOne: hold_one = d[HaltBit];
               AddrCtrlTwo: hold_two = d[HaltBit];
               AddrLenOne: if (en_one) len_one = LenReload[d[7:3]*8 +: 8];
               AddrLenTwo: if (en_two) len_two = LenReload[d[7:3]*8 +: 8];
               AddrPcmMode: begin
                  pcm_rd_mode = d[PcmModeBit];
                  irq_en      = d[IrqEnableBit];
               end
               AddrPcmDac: begin
                  // DAC writes are dropped in read mode; zero loads the IRQ flag from the enable
                  if (!pcm_rd_mode) begin
                     if (d == 8'd0) irq_pend = irq_en;
                     else dac_lvl = {d, 4'b0000};
                  end
               end
               AddrEnables: begin
                  en_one = d[EnableOneBit];
                  en_two = d[EnableTwoBit];
                  if (!en_one) len_one = 8'd0;
                  if (!en_two) len_two = 8'd0;
               end
               default: ;
            endcase
         end
         ReqStatusRd: r.read_data = {6'd0, len_two != 8'd0, len_one != 8'd0};
         default: begin
            // IRQ status is sampled before the flag clears
            r.read_data = {irq_pend && irq_en, 6'd0, pcm_rd_mode};
            irq_pend = 1'b0;
         end
      endcase
      r.dac_level = dac_lvl;
      r.irq_line  = irq_pend;
      predicted_responses.push_back(r);
   endfunction

   function automatic void queue_op(input logic [1:0] kind, input logic [15:0] a,
                                    input logic [7:0] d);
      bus_op_type op;
      op.kind = kind;
      op.addr = a;
      op.data = d;
      pending_bus_ops.push_back(op);
      queued_total++;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Random traffic: mostly short programming scenes (enable, length loads,
   // ticks, status read) so the length counters really run, mixed with
   // single random items and writes to dead addresses.
   task automatic queue_random_ops(input int unsigned count);
      int unsigned target;
      int unsigned pick;
      int unsigned n;
      logic [15:0] a;
      logic [7:0]  d;
      logic [1:0]  kind;
      target = queued_total + count;
      while (queued_total < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h03;
            queue_op(ReqWrite, AddrEnables, d);
            if ($urandom_range(0, 2) == 0)
               queue_op(ReqWrite, $urandom_range(0, 1) ? AddrCtrlOne : AddrCtrlTwo,
                        8'($urandom_range(0, 255)));
            queue_op(ReqWrite, AddrLenOne, 8'($urandom_range(0, 255)));
            queue_op(ReqWrite, AddrLenTwo, 8'($urandom_range(0, 255)));
            n = $urandom_range(1, 10);
            repeat (n) queue_op(ReqTick, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            queue_op(ReqStatusRd, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
         end else begin
            a = 16'($urandom_range(0, 65535));
            d = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 99);
            if (pick < 40)      kind = ReqTick;
            else if (pick < 78) kind = ReqWrite;
            else if (pick < 89) kind = ReqStatusRd;
            else                kind = ReqIrqRd;
            if (kind == ReqWrite) begin
               pick = $urandom_range(0, 99);
               if (pick < 70) begin
                  case ($urandom_range(0, 6))
                     0: a = AddrCtrlOne;
                     1: a = AddrLenOne;
                     2: a = AddrCtrlTwo;
                     3: a = AddrLenTwo;
                     4: a = AddrPcmMode;
                     5: a = AddrPcmDac;
                     default: a = AddrEnables;
                  endcase
               end else if (pick < 85) begin
                  a = AddrCtrlOne + 16'($urandom_range(0, 21));
               end
               // zero DAC writes load the IRQ flag from its enable; read mode mutes the DAC
               if (a == AddrPcmDac && $urandom_range(0, 3) == 0) d = 8'd0;
               if (a == AddrPcmMode && $urandom_range(0, 3) != 0) d[PcmModeBit] = 1'b0;
            end
            queue_op(kind, a, d);
         end
      end
   endtask

   // Idle means: nothing queued, nothing offered, nothing owed.
   task automatic wait_drained;
      while (pending_bus_ops.size() != 0 || req_valid || predicted_responses.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_period(input logic [13:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
   endtask

   // Config shadow follows the accepted CSR write
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) cfg_period <= csr_data;
   end

   // Driver: offers queued items in bursts with random gaps. The payload
   // holds until the item is taken; prediction happens at acceptance.
   always @(posedge clock) begin : drive_proc
      bus_op_type op;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_register_unit(req_type, req_addr, req_data);
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left  <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_bus_ops.size() != 0) begin
               op = pending_bus_ops.pop_front();
               req_valid <= 1'b1;
               req_type  <= op.kind;
               req_addr  <= op.addr;
               req_data  <= op.data;
               if (burst_left <= 1) begin
                  // occasional long burst gives stretches with no idling
                  burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250)
                                                           : $urandom_range(1, 40);
                  gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: switches between ready patterns every so often. A request
   // from the stimulus side starts one long hold-off so the output register
   // fills and the input backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_ask != stall_seen) begin
         stall_seen <= stall_ask;
         hold_left  <= LongHold;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            sink_mode <= sink_mode_type'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 128);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (sink_mode)
            SinkOpen:   rsp_ready <= 1'b1;
            SinkMostly: rsp_ready <= ($urandom_range(0, 3) != 0);
            SinkSparse: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:    rsp_ready <= 1'($urandom_range(0, 1));
         endcase
      end
   end

   // Monitor: every accepted response against the oldest prediction
   always @(posedge clock) begin : check_proc
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_responses.size() == 0) begin
            report_mismatch("unexpected item, read_data", rsp_read_data, 0);
         end else begin
            want = predicted_responses.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_dac_level !== want.dac_level)
               report_mismatch("dac_level", rsp_dac_level, want.dac_level);
            if (rsp_irq_line !== want.irq_line)
               report_mismatch("irq_line", rsp_irq_line, want.irq_line);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus_proc
      int unsigned phase;
      logic [13:0] period;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed pass at the reset period: status and IRQ reads from reset,
      // zero DAC write with IRQ off and on, DAC extremes, length load while
      // disabled, both loads with halt on one channel, the first tick
      // expiring at once, read mode muting DAC writes, dead addresses, and
      // disabling clearing the lengths.
      @(negedge clock);
      queue_op(ReqStatusRd, 16'h0000, 8'h00);
      queue_op(ReqIrqRd,    16'hFFFF, 8'hFF);
      queue_op(ReqWrite,    AddrPcmDac, 8'h00);
      queue_op(ReqWrite,    AddrPcmMode, 8'h80);
      queue_op(ReqWrite,    AddrPcmDac, 8'h00);
      queue_op(ReqIrqRd,    16'h0000, 8'h00);
      queue_op(ReqWrite,    AddrPcmDac, 8'hFF);
      queue_op(ReqWrite,    AddrPcmDac, 8'h01);
      queue_op(ReqWrite,    AddrLenOne, 8'hF8);
      queue_op(ReqWrite,    AddrEnables, 8'h03);
      queue_op(ReqWrite,    AddrLenOne, 8'hF8);
      queue_op(ReqWrite,    AddrLenTwo, 8'h08);
      queue_op(ReqWrite,    AddrCtrlOne, 8'h20);
      queue_op(ReqTick,     16'hFFFF, 8'hFF);
      queue_op(ReqStatusRd, 16'hFFFF, 8'hFF);
      queue_op(ReqWrite,    AddrPcmMode, 8'h81);
      queue_op(ReqWrite,    AddrPcmDac, 8'h40);
      queue_op(ReqWrite,    AddrPcmDac, 8'h00);
      queue_op(ReqIrqRd,    16'h0000, 8'h00);
      queue_op(ReqWrite,    16'h4FFF, 8'hFF);
      queue_op(ReqWrite,    16'h5014, 8'hFF);
      queue_op(ReqWrite,    16'hFFFF, 8'h00);
      queue_op(ReqWrite,    AddrEnables, 8'h00);
      queue_op(ReqStatusRd, 16'h0000, 8'h00);
      queue_op(ReqWrite,    AddrPcmMode, 8'h00);

      // Random phases, each at its own frame period; small periods keep the
      // length counters moving, the extremes include 0, 1 and all ones.
      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: period = 14'd2;
            1: period = 14'd0;
            2: period = 14'd16383;
            3: period = 14'd1;
            4: period = 14'd5;
            5: period = 14'd16382;
            6: period = 14'd3;
            7: period = 14'd37;
            default: period = FramePeriodReset;
         endcase
         wait_drained();
         write_period(period);
         @(negedge clock);
         if (phase == 4) begin
            // sender stops until every response is back, then resumes
            queue_random_ops(90);
            wait_drained();
            queue_random_ops(90);
         end else begin
            queue_random_ops(180);
         end
         if (phase == 1 || phase == 6) begin
            // long receiver hold-off while items are still on offer
            @(posedge clock);
            stall_ask <= stall_ask + 1;
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
